// ----- rtl/prescaled_countdown_timer_bank_unit_defines.svh -----
// assertion macros shared by the timer bank rtl
`ifndef PRESCALED_COUNTDOWN_TIMER_BANK_UNIT_DEFINES_SVH
`define PRESCALED_COUNTDOWN_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PCTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pctb_pkg.sv -----
`default_nettype none

package pctb_pkg;

   // number of countdown slots in the bank
   localparam int SLOTS = 8;

   // slot address and sweep counter widths
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);

   localparam int CNTR_W  = 17;
   localparam int IVL_W   = 16;

   localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd10;

   // csr address: one 32 bit register, byte addressed
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-3:0] REG_TICK_INTERVAL = '0;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef struct packed {
      logic expired;
      logic active;
      logic slot_invalid;
      logic step_done;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/pctb_ram.sv -----
`default_nettype none

module pctb_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/prescaled_countdown_timer_bank_unit.sv -----
// Bank of SLOTS countdown timers behind a millisecond prescaler. A tick request
// bumps the prescale accumulator; when it reaches tick_interval it wraps to zero
// and every slot above 1 counts down by one (step_done is set in the response).
// Start loads ticks+1 (1 when ticks is 0), stop clears the slot, query reports
// expired (counter is 1) and active (counter non-zero). A start, stop or query
// with a slot index at or above SLOTS changes nothing and answers with
// slot_invalid. Each request gives exactly one response transfer. Counters live in
// a single-port-read RAM; a query does one RAM read, and a tick that wraps sweeps
// the bank, reading one slot per cycle through the RAM's read port and writing it
// back in the next cycle. A new request is taken as soon as the sequencer is idle,
// even while the last response still waits for rsp_ready. After reset every slot
// reads as zero at once (per-slot valid flags), so there is no clearing pass.
// tick_interval sits at csr byte address 0; a written zero is stored as one.
`default_nettype none

`include "prescaled_countdown_timer_bank_unit_defines.svh"

module prescaled_countdown_timer_bank_unit
   import pctb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   // request channel
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [7:0]        req_slot,
   input  wire logic [15:0]       req_ticks,

   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              rsp_expired,
   output      logic              rsp_active,
   output      logic              rsp_slot_invalid,
   output      logic              rsp_step_done,

   // apb-style csr port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_SWEEP,
      ST_HOLD
   } state_type;

   // sequencer and result staging
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;
   result_type         pend_ff, pend_in;

   // prescaler and csr
   logic [IVL_W-1:0]   accum_ff, accum_in;
   logic [IVL_W-1:0]   interval_ff, interval_in;

   // sweep bookkeeping
   logic [CNT_W-1:0]   sw_idx_ff, sw_idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [SLOT_AW-1:0] wb_addr_ff, wb_addr_in;

   // per-slot written flags, cleared by reset
   logic [SLOTS-1:0]   vld_ff, vld_in;
   logic               rd_vld_ff, rd_vld_in;

   // ram port
   logic               mem_wr_en;
   logic [SLOT_AW-1:0] mem_wr_addr;
   logic [CNTR_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [SLOT_AW-1:0] mem_rd_addr;
   logic [CNTR_W-1:0]  mem_rd_data;

   // combinational helpers
   logic               rsp_free;
   logic               fin_en;
   result_type         fin_res;
   logic [IVL_W:0]     accum_inc;
   logic               slot_bad;
   logic [CNTR_W-1:0]  rd_val;
   logic               csr_wr;
   logic               csr_hit;
   logic [IVL_W-1:0]   csr_ivl;

   pctb_ram #(
      .WIDTH (CNTR_W),
      .DEPTH (SLOTS)
   ) u_cntr_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired      = rsp_res_ff.expired;
   assign rsp_active       = rsp_res_ff.active;
   assign rsp_slot_invalid = rsp_res_ff.slot_invalid;
   assign rsp_step_done    = rsp_res_ff.step_done;

   // csr access, always ready, combinational read data
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_AW-1:2] == REG_TICK_INTERVAL);
   assign csr_wr  = psel && penable && pwrite && csr_hit;
   assign csr_ivl = (pwdata[IVL_W-1:0] == '0) ? IVL_W'(1) : pwdata[IVL_W-1:0];
   assign prdata  = csr_hit ? {{(32-IVL_W){1'b0}}, interval_ff} : '0;

   // shared derived values
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign accum_inc = {1'b0, accum_ff} + (IVL_W+1)'(1);
   assign slot_bad  = ({1'b0, req_slot} >= 9'(SLOTS));
   // a slot never written reads as zero
   assign rd_val    = rd_vld_ff ? mem_rd_data : '0;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      pend_in      = pend_ff;
      accum_in     = accum_ff;
      interval_in  = interval_ff;
      sw_idx_in    = sw_idx_ff;
      rd_pend_in   = rd_pend_ff;
      wb_addr_in   = wb_addr_ff;
      vld_in       = vld_ff;
      rd_vld_in    = rd_vld_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = req_slot[SLOT_AW-1:0];
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = req_slot[SLOT_AW-1:0];
      fin_en       = 1'b0;
      fin_res      = '0;

      if (csr_wr) begin
         interval_in = csr_ivl;
      end

      // response taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (opcode_type'(req_opcode) == OP_TICK) begin
                  if (accum_inc >= {1'b0, interval_ff}) begin
                     // prescaler wraps: count every slot down
                     accum_in   = '0;
                     sw_idx_in  = '0;
                     rd_pend_in = 1'b0;
                     state_in   = ST_SWEEP;
                  end else begin
                     accum_in = accum_inc[IVL_W-1:0];
                     fin_en   = 1'b1;
                  end
               end else if (slot_bad) begin
                  fin_en               = 1'b1;
                  fin_res.slot_invalid = 1'b1;
               end else begin
                  unique case (opcode_type'(req_opcode))
                     OP_START: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = (req_ticks == '0) ? CNTR_W'(1)
                                                        : {1'b0, req_ticks} + CNTR_W'(1);
                        fin_en      = 1'b1;
                     end
                     OP_STOP: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '0;
                        fin_en      = 1'b1;
                     end
                     OP_QUERY: begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_QUERY;
                     end
                     OP_TICK: begin
                        // handled above
                     end
                  endcase
               end
            end
         end

         ST_QUERY: begin
            fin_en          = 1'b1;
            fin_res.expired = (rd_val == CNTR_W'(1));
            fin_res.active  = (rd_val != '0);
         end

         ST_SWEEP: begin
            // read slot i while writing back slot i-1
            if (sw_idx_ff != CNT_W'(SLOTS)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = sw_idx_ff[SLOT_AW-1:0];
               sw_idx_in   = sw_idx_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
            wb_addr_in = sw_idx_ff[SLOT_AW-1:0];
            if (rd_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wb_addr_ff;
               mem_wr_data = (rd_val > CNTR_W'(1)) ? rd_val - CNTR_W'(1) : rd_val;
            end
            if (sw_idx_ff == CNT_W'(SLOTS)) begin
               fin_en            = 1'b1;
               fin_res.step_done = 1'b1;
            end
         end

         ST_HOLD: begin
            if (rsp_free) begin
               rsp_res_in   = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase

      // finished item goes to the output register or waits in the holding stage
      if (fin_en) begin
         if (rsp_free) begin
            rsp_res_in   = fin_res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = ST_HOLD;
         end
      end

      if (mem_wr_en) begin
         vld_in[mem_wr_addr] = 1'b1;
      end
      if (mem_rd_en) begin
         rd_vld_in = vld_ff[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         accum_ff     <= '0;
         interval_ff  <= INTERVAL_RESET;
         sw_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         accum_ff     <= accum_in;
         interval_ff  <= interval_in;
         sw_idx_ff    <= sw_idx_in;
         rd_pend_ff   <= rd_pend_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= rd_vld_in;
      end
      rsp_res_ff <= rsp_res_in;
      pend_ff    <= pend_in;
      wb_addr_ff <= wb_addr_in;
   end

   // sweep write-back never targets the slot being read
   `PCTB_ASSERT_NOW(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en,
      mem_wr_addr != mem_rd_addr, "ram read and write hit the same slot")

   // sweep counter stays within the bank
   `PCTB_ASSERT_NOW(a_sweep_range, clock, reset, state_ff == ST_SWEEP,
      sw_idx_ff <= CNT_W'(SLOTS), "sweep index ran past the last slot")

   // an accepted request is either still in work or already shown
   `PCTB_ASSERT_NEXT(a_accept_progress, clock, reset, req_valid && req_ready,
      state_ff != ST_IDLE || rsp_valid_ff, "accepted request left no trace")

   // holding stage is only used while the output register is occupied
   `PCTB_ASSERT_NOW(a_hold_needs_full, clock, reset, state_ff == ST_HOLD,
      rsp_valid_ff, "result held although output register is empty")

endmodule

`default_nettype wire
